[hdl/ssc_pkg.sv]
package ssc_pkg;

   localparam int CUR_W  = 16;
   localparam int CNT_W  = 16;
   localparam int PF_W   = 8;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_RATING_CURRENT   = 3'd0;
   localparam logic [2:0] REG_RISE_COUNT_LIMIT = 3'd1;
   localparam logic [2:0] REG_DESCEND_DELAY    = 3'd2;
   localparam logic [2:0] REG_PF_THRESHOLD     = 3'd3;
   localparam logic [2:0] REG_RATING_MODE      = 3'd4;
   localparam logic [2:0] REG_SAMPLE_TEST      = 3'd5;
   localparam logic [2:0] REG_MIN_DRIVE_LEVEL  = 3'd6;

   localparam logic [CNT_W-1:0] RISE_LIMIT_RESET = 16'd100;

   // voltage gates and fixed descent counts
   localparam logic [CUR_W-1:0] VOLT_GATE   = 16'd50;
   localparam logic [CUR_W-1:0] VOLT_A_GATE = 16'd20;
   localparam logic [CNT_W-1:0] DROP_LIMIT  = 16'd2;
   localparam logic [CNT_W-1:0] DELAY_LIMIT = 16'd2;

   typedef struct packed {
      logic [CUR_W-1:0]       rating_current;
      logic [CNT_W-1:0]       rise_count_limit;
      logic [CNT_W-1:0]       descend_delay;
      logic signed [PF_W-1:0] pf_threshold;
      logic                   rating_mode;
      logic                   sample_test;
      logic [CUR_W-1:0]       min_drive_level;
   } cfg_type;

   typedef struct packed {
      logic                   advance;
      logic                   starting;
      logic [CUR_W-1:0]       cur;
      logic [CUR_W-1:0]       volt_gate;
      logic [CUR_W-1:0]       volt_a;
      logic signed [PF_W-1:0] pf;
   } phase_in_type;

   typedef struct packed {
      logic forced;
      logic run_set;
   } phase_out_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage

[hdl/ssc_csr.sv]
module ssc_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [ssc_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [ssc_pkg::DATA_W-1:0] csr_pwdata,
   output logic [ssc_pkg::DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output ssc_pkg::cfg_type           cfg
);
   import ssc_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rating_current   <= '0;
         cfg_ff.rise_count_limit <= RISE_LIMIT_RESET;
         cfg_ff.descend_delay    <= '0;
         cfg_ff.pf_threshold     <= '0;
         cfg_ff.rating_mode      <= 1'b0;
         cfg_ff.sample_test      <= 1'b0;
         cfg_ff.min_drive_level  <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_RATING_CURRENT:   cfg_ff.rating_current   <= csr_pwdata[CUR_W-1:0];
            REG_RISE_COUNT_LIMIT: cfg_ff.rise_count_limit <= csr_pwdata[CNT_W-1:0];
            REG_DESCEND_DELAY:    cfg_ff.descend_delay    <= csr_pwdata[CNT_W-1:0];
            REG_PF_THRESHOLD:     cfg_ff.pf_threshold     <= csr_pwdata[PF_W-1:0];
            REG_RATING_MODE:      cfg_ff.rating_mode      <= csr_pwdata[0];
            REG_SAMPLE_TEST:      cfg_ff.sample_test      <= csr_pwdata[0];
            REG_MIN_DRIVE_LEVEL:  cfg_ff.min_drive_level  <= csr_pwdata[CUR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_RATING_CURRENT:   csr_prdata = {16'd0, cfg_ff.rating_current};
         REG_RISE_COUNT_LIMIT: csr_prdata = {16'd0, cfg_ff.rise_count_limit};
         REG_DESCEND_DELAY:    csr_prdata = {16'd0, cfg_ff.descend_delay};
         REG_PF_THRESHOLD:     csr_prdata = {{24{cfg_ff.pf_threshold[PF_W-1]}},
                                              cfg_ff.pf_threshold};
         REG_RATING_MODE:      csr_prdata = {31'd0, cfg_ff.rating_mode};
         REG_SAMPLE_TEST:      csr_prdata = {31'd0, cfg_ff.sample_test};
         REG_MIN_DRIVE_LEVEL:  csr_prdata = {16'd0, cfg_ff.min_drive_level};
         default:              csr_prdata = '0;
      endcase
   end

endmodule

[hdl/ssc_phase.sv]
module ssc_phase (
   input  logic                   clock,
   input  logic                   reset,
   input  ssc_pkg::cfg_type       cfg,
   input  ssc_pkg::phase_in_type  pin,
   output ssc_pkg::phase_out_type pout
);
   import ssc_pkg::*;

   logic [CNT_W-1:0] rise_ff, rise_in;
   logic             armed_ff, armed_in;
   logic [CUR_W-1:0] peak_ff, peak_in;
   logic [CNT_W-1:0] drop_ff, drop_in;
   logic [CNT_W-1:0] delay_ff, delay_in;
   logic [CUR_W-1:0] half;
   logic             pf_ok;

   assign half  = peak_ff >> 1;
   assign pf_ok = cfg.sample_test && (pin.pf >= cfg.pf_threshold);

   always_comb begin
      rise_in      = rise_ff;
      armed_in     = armed_ff;
      peak_in      = peak_ff;
      drop_in      = drop_ff;
      delay_in     = delay_ff;
      pout.forced  = 1'b0;
      pout.run_set = 1'b0;
      if (!pin.starting) begin
         rise_in  = '0;
         armed_in = 1'b0;
         drop_in  = '0;
         peak_in  = '0;
      end else begin
         if (pin.cur > cfg.rating_current && !armed_ff) begin
            if (rise_ff < cfg.rise_count_limit) rise_in = rise_ff + 1'b1;
            else armed_in = 1'b1;
         end
         // tracking starts in the same tick the phase arms
         if (armed_in) begin
            if (pin.cur > peak_ff) begin
               peak_in = pin.cur;
            end else if (pin.cur < peak_ff && pin.volt_gate > VOLT_GATE) begin
               if (pin.cur < half && !cfg.rating_mode) begin
                  drop_in = sat_inc(drop_ff);
                  if (drop_in > DROP_LIMIT) begin
                     pout.forced = 1'b1;
                     delay_in    = sat_inc(delay_ff);
                     if (delay_in > cfg.descend_delay && !cfg.sample_test)
                        pout.run_set = 1'b1;
                  end
               end else if (pin.cur < cfg.rating_current && cfg.rating_mode &&
                            pin.volt_a > VOLT_A_GATE) begin
                  delay_in = sat_inc(delay_ff);
                  if ((delay_in > DELAY_LIMIT && !cfg.sample_test) || pf_ok)
                     pout.run_set = 1'b1;
               end else if (pf_ok) begin
                  pout.run_set = 1'b1;
               end else begin
                  delay_in = '0;
                  drop_in  = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff  <= '0;
         armed_ff <= 1'b0;
         peak_ff  <= '0;
         drop_ff  <= '0;
         delay_ff <= '0;
      end else if (pin.advance) begin
         rise_ff  <= rise_in;
         armed_ff <= armed_in;
         peak_ff  <= peak_in;
         drop_ff  <= drop_in;
         delay_ff <= delay_in;
      end
   end

endmodule

[hdl/soft_start_completion_detector.sv]
// Soft-start completion detector. One measurement beat per control tick goes in on the req_
// channel and exactly one result beat comes out on rsp_, in order. A beat is registered at the
// input, then evaluated against the per-phase state in one pass and written to the result
// register, from which it is presented on rsp_; one beat per cycle is sustained while rsp_stall
// stays low. The input register can still take a beat while a result waits on rsp_stall,
// and only a full input register with a blocked result register stalls req_. Registers on the
// csr_ port must be written only while no beat is in flight; the block does not enforce this.
module soft_start_completion_detector (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ssc_pkg::CUR_W-1:0]   req_current_a,
   input  logic [ssc_pkg::CUR_W-1:0]   req_current_b,
   input  logic [ssc_pkg::CUR_W-1:0]   req_current_c,
   input  logic [ssc_pkg::CUR_W-1:0]   req_voltage_a,
   input  logic [ssc_pkg::CUR_W-1:0]   req_voltage_c,
   input  logic signed [ssc_pkg::PF_W-1:0] req_power_factor,
   input  logic                        req_starting_active,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_run_switch,
   output logic                        rsp_overcurrent_seen,
   output logic                        rsp_force_min_drive,
   output logic [ssc_pkg::CUR_W-1:0]   rsp_drive_level,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [ssc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [ssc_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [ssc_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import ssc_pkg::*;

   cfg_type cfg;

   logic                   in_valid_ff;
   logic [CUR_W-1:0]       ia_ff, ib_ff, ic_ff, ua_ff, uc_ff;
   logic signed [PF_W-1:0] pf_ff;
   logic                   start_ff;

   logic                   out_valid_ff;
   logic                   run_sw_ff, oc_seen_ff, forced_ff;
   logic [CUR_W-1:0]       level_ff;

   logic                   run_latch_ff, run_latch_in;
   logic                   oc_latch_ff, oc_latch_in;
   logic                   advance, req_take, forced;

   phase_in_type  pin_a, pin_c;
   phase_out_type pout_a, pout_c;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   ssc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign pin_a = '{advance: advance, starting: start_ff, cur: ia_ff,
                    volt_gate: ua_ff, volt_a: ua_ff, pf: pf_ff};
   // phase c gates on its own voltage but uses phase a for the low gate
   assign pin_c = '{advance: advance, starting: start_ff, cur: ic_ff,
                    volt_gate: uc_ff, volt_a: ua_ff, pf: pf_ff};

   ssc_phase u_phase_a (.clock(clock), .reset(reset), .cfg(cfg), .pin(pin_a), .pout(pout_a));
   ssc_phase u_phase_c (.clock(clock), .reset(reset), .cfg(cfg), .pin(pin_c), .pout(pout_c));

   always_comb begin
      forced       = start_ff && (pout_a.forced || pout_c.forced);
      run_latch_in = run_latch_ff || (start_ff && (pout_a.run_set || pout_c.run_set));
      oc_latch_in  = oc_latch_ff || (start_ff && (ia_ff > cfg.rating_current ||
                     ib_ff > cfg.rating_current || ic_ff > cfg.rating_current));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         run_latch_ff <= 1'b0;
         oc_latch_ff  <= 1'b0;
      end else begin
         if (req_take) in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;
         if (advance) begin
            out_valid_ff <= 1'b1;
            run_latch_ff <= run_latch_in;
            oc_latch_ff  <= oc_latch_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload beats, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         ia_ff    <= req_current_a;
         ib_ff    <= req_current_b;
         ic_ff    <= req_current_c;
         ua_ff    <= req_voltage_a;
         uc_ff    <= req_voltage_c;
         pf_ff    <= req_power_factor;
         start_ff <= req_starting_active;
      end
      if (advance) begin
         run_sw_ff  <= run_latch_in;
         oc_seen_ff <= oc_latch_in;
         forced_ff  <= forced;
         level_ff   <= forced ? cfg.min_drive_level : '0;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_run_switch       = run_sw_ff;
   assign rsp_overcurrent_seen = oc_seen_ff;
   assign rsp_force_min_drive  = forced_ff;
   assign rsp_drive_level      = level_ff;

endmodule

[tb/soft_start_completion_detector_tb.sv]
module soft_start_completion_detector_tb;

   import ssc_pkg::*;

   localparam logic [15:0] GATE_VOLTS        = 16'd50;
   localparam logic [15:0] VOLT_A_MIN        = 16'd20;
   localparam logic [15:0] DROP_COUNT_LIMIT  = 16'd2;
   localparam logic [15:0] DELAY_COUNT_LIMIT = 16'd2;
   localparam int unsigned RANDOM_ITEMS      = 1350;
   localparam int unsigned DRAIN_CYCLES      = 6;
   localparam int unsigned QUIET_LIMIT       = 2000;

   typedef struct packed {
      logic [15:0]       current_a;
      logic [15:0]       current_b;
      logic [15:0]       current_c;
      logic [15:0]       voltage_a;
      logic [15:0]       voltage_c;
      logic signed [7:0] power_factor;
      logic              starting_active;
   } meas_type;

   typedef struct packed {
      logic        run_switch;
      logic        overcurrent_seen;
      logic        force_min_drive;
      logic [15:0] drive_level;
   } result_type;

   typedef struct packed {
      logic [15:0] rise;
      logic        armed;
      logic [15:0] peak;
      logic [15:0] drop;
      logic [15:0] delay;
   } phase_track_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [15:0]       req_current_a;
   logic [15:0]       req_current_b;
   logic [15:0]       req_current_c;
   logic [15:0]       req_voltage_a;
   logic [15:0]       req_voltage_c;
   logic signed [7:0] req_power_factor;
   logic              req_starting_active;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_run_switch;
   logic              rsp_overcurrent_seen;
   logic              rsp_force_min_drive;
   logic [15:0]       rsp_drive_level;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   // predictor copy of the block
   cfg_type         cfg;
   phase_track_type track_a;
   phase_track_type track_c;
   logic            run_flag;
   logic            overcurrent_flag;
   result_type      pending_results[$];

   logic        send_gaps = 1'b1;
   logic        recv_gaps = 1'b1;
   int unsigned hold_off_cycles = 0;
   int unsigned items_sent = 0;
   int unsigned results_checked = 0;
   int unsigned settings_applied = 0;
   int unsigned mismatches = 0;

   soft_start_completion_detector dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_current_a        (req_current_a),
      .req_current_b        (req_current_b),
      .req_current_c        (req_current_c),
      .req_voltage_a        (req_voltage_a),
      .req_voltage_c        (req_voltage_c),
      .req_power_factor     (req_power_factor),
      .req_starting_active  (req_starting_active),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_run_switch       (rsp_run_switch),
      .rsp_overcurrent_seen (rsp_overcurrent_seen),
      .rsp_force_min_drive  (rsp_force_min_drive),
      .rsp_drive_level      (rsp_drive_level),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [15:0] bump_sat(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   task automatic advance_phase(inout phase_track_type p, input logic [15:0] cur,
                                input logic [15:0] gate_volts, input logic [15:0] volt_a,
                                input logic signed [7:0] pf, output logic forced);
      logic pf_ok;
      forced = 1'b0;
      pf_ok = cfg.sample_test && ($signed(pf) >= $signed(cfg.pf_threshold));
      if (cur > cfg.rating_current && !p.armed) begin
         if (p.rise < cfg.rise_count_limit) begin
            p.rise = p.rise + 16'd1;
         end else begin
            p.armed = 1'b1;
         end
      end
      if (p.armed) begin
         if (cur > p.peak) begin
            p.peak = cur;
         end else if (cur < p.peak && gate_volts > GATE_VOLTS) begin
            if (cur < (p.peak >> 1) && !cfg.rating_mode) begin
               p.drop = bump_sat(p.drop);
               if (p.drop > DROP_COUNT_LIMIT) begin
                  forced = 1'b1;
                  p.delay = bump_sat(p.delay);
                  if (p.delay > cfg.descend_delay && !cfg.sample_test) run_flag = 1'b1;
               end
            end else if (cur < cfg.rating_current && cfg.rating_mode && volt_a > VOLT_A_MIN) begin
               p.delay = bump_sat(p.delay);
               if (p.delay > DELAY_COUNT_LIMIT && !cfg.sample_test) run_flag = 1'b1;
               if (pf_ok) run_flag = 1'b1;
            end else if (pf_ok) begin
               run_flag = 1'b1;
            end else begin
               p.delay = 16'd0;
               p.drop = 16'd0;
            end
         end
      end
   endtask

   task automatic predict_result(input meas_type m);
      logic       forced_a;
      logic       forced_c;
      result_type r;
      forced_a = 1'b0;
      forced_c = 1'b0;
      if (m.starting_active) begin
         if (m.current_a > cfg.rating_current || m.current_b > cfg.rating_current ||
             m.current_c > cfg.rating_current) overcurrent_flag = 1'b1;
         advance_phase(track_a, m.current_a, m.voltage_a, m.voltage_a, m.power_factor, forced_a);
         advance_phase(track_c, m.current_c, m.voltage_c, m.voltage_a, m.power_factor, forced_c);
      end else begin
         track_a.rise = 16'd0;
         track_c.rise = 16'd0;
         track_a.armed = 1'b0;
         track_c.armed = 1'b0;
         track_a.drop = 16'd0;
         track_c.drop = 16'd0;
         track_a.peak = 16'd0;
         track_c.peak = 16'd0;
      end
      r.run_switch = run_flag;
      r.overcurrent_seen = overcurrent_flag;
      r.force_min_drive = forced_a || forced_c;
      r.drive_level = (forced_a || forced_c) ? cfg.min_drive_level : 16'd0;
      pending_results.push_back(r);
   endtask

   task automatic send_measurement(input meas_type m);
      int unsigned gap;
      gap = send_gaps ? $urandom_range(0, 14) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_current_a <= m.current_a;
      req_current_b <= m.current_b;
      req_current_c <= m.current_c;
      req_voltage_a <= m.voltage_a;
      req_voltage_c <= m.voltage_c;
      req_power_factor <= m.power_factor;
      req_starting_active <= m.starting_active;
      do @(posedge clock); while (!(req_valid && !req_stall));
      predict_result(m);
      items_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_RATING_CURRENT:   cfg.rating_current = value[15:0];
         REG_RISE_COUNT_LIMIT: cfg.rise_count_limit = value[15:0];
         REG_DESCEND_DELAY:    cfg.descend_delay = value[15:0];
         REG_PF_THRESHOLD:     cfg.pf_threshold = value[7:0];
         REG_RATING_MODE:      cfg.rating_mode = value[0];
         REG_SAMPLE_TEST:      cfg.sample_test = value[0];
         REG_MIN_DRIVE_LEVEL:  cfg.min_drive_level = value[15:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(input logic [15:0] rating, input logic [15:0] rise_limit,
                               input logic [15:0] delay, input logic signed [7:0] pf_thr,
                               input logic mode, input logic test_mode,
                               input logic [15:0] drive);
      write_reg(REG_RATING_CURRENT, {16'd0, rating});
      write_reg(REG_RISE_COUNT_LIMIT, {16'd0, rise_limit});
      write_reg(REG_DESCEND_DELAY, {16'd0, delay});
      write_reg(REG_PF_THRESHOLD, {{24{pf_thr[7]}}, pf_thr});
      write_reg(REG_RATING_MODE, {31'd0, mode});
      write_reg(REG_SAMPLE_TEST, {31'd0, test_mode});
      write_reg(REG_MIN_DRIVE_LEVEL, {16'd0, drive});
      settings_applied++;
   endtask

   function automatic meas_type make_measurement(input int cur_a, input int cur_b,
                                                 input int cur_c, input int volt_a,
                                                 input int volt_c, input int pf,
                                                 input logic starting);
      meas_type m;
      m.current_a = cur_a[15:0];
      m.current_b = cur_b[15:0];
      m.current_c = cur_c[15:0];
      m.voltage_a = volt_a[15:0];
      m.voltage_c = volt_c[15:0];
      m.power_factor = pf[7:0];
      m.starting_active = starting;
      return m;
   endfunction

   function automatic logic [15:0] pick_current(input int unsigned rise_pct);
      int r;
      int v;
      int unsigned roll;
      r = int'(cfg.rating_current);
      roll = $urandom_range(0, 99);
      if (roll < rise_pct) begin
         v = r + int'($urandom_range(1, 3000));
      end else if (roll < rise_pct + 8) begin
         v = int'($urandom_range(0, 65535));
      end else if (roll < rise_pct + 25) begin
         // between half rating and a bit above it
         v = int'($urandom_range(r / 2, r + 1500));
      end else begin
         v = int'($urandom_range(0, r / 3));
      end
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic logic [15:0] pick_voltage();
      if ($urandom_range(0, 4) == 0) begin
         return 16'($urandom_range(0, 60));
      end else begin
         return 16'($urandom_range(51, 65535));
      end
   endfunction

   function automatic meas_type episode_tick(input int unsigned step, input int unsigned len);
      meas_type m;
      int       pf;
      pf = int'($urandom_range(0, 200)) - 100;
      m.current_a = pick_current((step < len / 3) ? 85 : 15);
      m.current_b = pick_current((step < len / 3) ? 85 : 15);
      m.current_c = pick_current((step < len / 3) ? 85 : 15);
      m.voltage_a = pick_voltage();
      m.voltage_c = pick_voltage();
      m.power_factor = pf[7:0];
      m.starting_active = ($urandom_range(0, 19) != 0);
      return m;
   endfunction

   function automatic meas_type random_noise();
      int pf;
      pf = int'($urandom_range(0, 200)) - 100;
      return make_measurement($urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), pf, $urandom_range(0, 3) == 0);
   endfunction

   task automatic randomize_config();
      int unsigned roll;
      logic [15:0] rating;
      logic [15:0] rise_limit;
      logic [15:0] delay;
      int          pf_thr;
      logic [15:0] drive;
      roll = $urandom_range(0, 9);
      if (roll == 0) rating = 16'd0;
      else if (roll == 1) rating = 16'hFFFF;
      else if (roll < 6) rating = 16'($urandom_range(1, 200));
      else rating = 16'($urandom_range(0, 20000));
      roll = $urandom_range(0, 9);
      rise_limit = (roll == 0) ? 16'hFFFF : 16'($urandom_range(0, 6));
      roll = $urandom_range(0, 9);
      delay = (roll == 0) ? 16'hFFFF : 16'($urandom_range(0, 8));
      pf_thr = int'($urandom_range(0, 200)) - 100;
      roll = $urandom_range(0, 9);
      if (roll == 0) drive = 16'd0;
      else if (roll == 1) drive = 16'hFFFF;
      else drive = 16'($urandom_range(0, 65535));
      apply_config(rating, rise_limit, delay, pf_thr[7:0], 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), drive);
   endtask

   // result sink: random stalls plus an occasional long hold-off
   initial begin : result_sink
      int unsigned hold;
      rsp_stall = 1'b0;
      forever begin
         if (hold_off_cycles != 0) begin
            hold = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            hold = recv_gaps ? $urandom_range(0, 14) : 0;
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : result_checker
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no measurement outstanding");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("run_switch", 16'(want.run_switch), 16'(rsp_run_switch));
            check_field("overcurrent_seen", 16'(want.overcurrent_seen),
                        16'(rsp_overcurrent_seen));
            check_field("force_min_drive", 16'(want.force_min_drive),
                        16'(rsp_force_min_drive));
            check_field("drive_level", want.drive_level, rsp_drive_level);
            results_checked++;
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_psel && csr_penable && csr_pwrite)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("soft_start_completion_detector_tb failed");
      $finish;
   end

   // overcurrent latches only while starting, with the power-on settings
   task automatic test_power_on_defaults();
      send_measurement(make_measurement(0, 0, 0, 0, 0, 0, 1'b1));
      send_measurement(make_measurement(65535, 65535, 65535, 100, 100, 0, 1'b0));
      send_measurement(make_measurement(0, 1, 0, 100, 100, 0, 1'b1));
      wait_idle();
   endtask

   task automatic test_field_extremes();
      apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, -8'sd100, 1'b1, 1'b1, 16'hFFFF);
      send_measurement(make_measurement(65535, 65535, 65535, 65535, 65535, 100, 1'b1));
      send_measurement(make_measurement(0, 0, 0, 0, 0, -100, 1'b1));
      send_measurement(make_measurement(65535, 0, 65535, 0, 65535, -1, 1'b0));
      send_measurement(make_measurement(0, 65535, 0, 65535, 0, 0, 1'b1));
      wait_idle();
   endtask

   task automatic test_half_peak_rule();
      apply_config(16'd1000, 16'd0, 16'd3, 8'sd0, 1'b0, 1'b0, 16'h1234);
      send_measurement(make_measurement(0, 0, 0, 100, 100, 0, 1'b0));
      send_measurement(make_measurement(2000, 0, 2000, 100, 100, 0, 1'b1));
      send_measurement(make_measurement(500, 0, 500, 100, 100, 0, 1'b1));
      send_measurement(make_measurement(500, 0, 500, 100, 100, 0, 1'b1));
      send_measurement(make_measurement(500, 0, 500, 100, 100, 0, 1'b1));
      // phase c voltage at the gate: only phase a moves on
      send_measurement(make_measurement(500, 0, 500, 100, 50, 0, 1'b1));
      send_measurement(make_measurement(1500, 0, 1500, 100, 100, 0, 1'b1));
      wait_idle();
   endtask

   task automatic test_below_rating_rule();
      apply_config(16'd1000, 16'd0, 16'd0, 8'sd0, 1'b1, 1'b0, 16'h0F0F);
      send_measurement(make_measurement(0, 0, 0, 100, 100, 0, 1'b0));
      send_measurement(make_measurement(1500, 0, 1500, 100, 100, 0, 1'b1));
      send_measurement(make_measurement(500, 0, 500, 100, 100, 0, 1'b1));
      send_measurement(make_measurement(500, 0, 500, 21, 100, 0, 1'b1));
      send_measurement(make_measurement(500, 0, 500, 20, 100, 0, 1'b1));
      wait_idle();
   endtask

   // signed threshold compare in test mode
   task automatic test_power_factor_rule();
      apply_config(16'd1000, 16'd0, 16'd0, -8'sd20, 1'b0, 1'b1, 16'h00FF);
      send_measurement(make_measurement(0, 0, 0, 100, 100, 0, 1'b0));
      send_measurement(make_measurement(2000, 0, 2000, 100, 100, 0, 1'b1));
      send_measurement(make_measurement(1500, 0, 1500, 100, 100, -21, 1'b1));
      send_measurement(make_measurement(1500, 0, 1500, 100, 100, -20, 1'b1));
      send_measurement(make_measurement(300, 0, 300, 100, 100, 100, 1'b1));
      wait_idle();
   endtask

   task automatic test_result_backpressure();
      int unsigned n;
      send_gaps = 1'b0;
      hold_off_cycles = 80;
      for (n = 0; n < 24; n++) begin
         send_measurement(episode_tick(n, 24));
      end
      wait_idle();
      send_gaps = 1'b1;
   endtask

   task automatic test_random_starts();
      int unsigned sent;
      int unsigned episodes;
      int unsigned len;
      int unsigned step;
      int unsigned noise;
      sent = 0;
      episodes = 0;
      while (sent < RANDOM_ITEMS) begin
         if (episodes % 6 == 0) begin
            wait_idle();
            randomize_config();
         end
         send_gaps = ($urandom_range(0, 3) != 0);
         recv_gaps = ($urandom_range(0, 3) != 0);
         len = $urandom_range(8, 30);
         for (step = 0; step < len; step++) begin
            send_measurement(episode_tick(step, len));
            sent++;
         end
         noise = $urandom_range(1, 3);
         repeat (noise) begin
            send_measurement(random_noise());
            sent++;
         end
         episodes++;
      end
      wait_idle();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_current_a = '0;
      req_current_b = '0;
      req_current_c = '0;
      req_voltage_a = '0;
      req_voltage_c = '0;
      req_power_factor = '0;
      req_starting_active = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cfg = '0;
      cfg.rise_count_limit = 16'd100;
      track_a = '0;
      track_c = '0;
      run_flag = 1'b0;
      overcurrent_flag = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_on_defaults();
      test_field_extremes();
      test_half_peak_rule();
      test_below_rating_rule();
      test_power_factor_rule();
      test_result_backpressure();
      test_random_starts();

      $display("ran %0d measurement beats under %0d register settings,", items_sent,
               settings_applied);
      $display("incl. a long result hold-off that fills the block; %0d results compared",
               results_checked);
      if (mismatches == 0) begin
         $display("soft_start_completion_detector_tb passed");
      end else begin
         $display("soft_start_completion_detector_tb failed");
      end
      $finish;
   end

endmodule
